[design/mrx_pkg.sv]
// ----------------------------------------------------------------------------
// mrx_pkg
// Shared types and constants of the MQTT receive deframer: parser phases,
// body byte kinds, control packet type codes and the result record.
// ----------------------------------------------------------------------------
package mrx_pkg;

  localparam int MRX_MAX_LEN_BYTES = 4;

  localparam int LEN_W   = 28;
  localparam int CNT_W   = 3;
  localparam int TOPIC_W = 16;

  localparam logic [3:0] TYPE_CONNACK = 4'd2;
  localparam logic [3:0] TYPE_PUBLISH = 4'd3;
  localparam logic [1:0] QOS_ONE      = 2'd1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    KIND_OTHER   = 3'd0,
    KIND_TOPLEN  = 3'd1,
    KIND_TOPIC   = 3'd2,
    KIND_PKTID   = 3'd3,
    KIND_PAYLOAD = 3'd4
  } kind_t;

  typedef struct packed {
    logic [3:0]  frame_type;
    logic [3:0]  frame_flags;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic [2:0]  data_kind;
    logic        frame_end;
    logic        connack_ok;
    logic        connack_reject;
    logic        puback_due;
    logic [15:0] puback_id;
    logic        malformed;
  } mrx_result_t;

endpackage

[design/mrx_if.sv]
// ----------------------------------------------------------------------------
// mrx_if
// Valid/ready channels of the deframer: received bytes in, results out.
// ----------------------------------------------------------------------------
interface mrx_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mrx_result_if;
  logic        valid;
  logic        ready;
  logic [3:0]  frame_type;
  logic [3:0]  frame_flags;
  logic        data_valid;
  logic [7:0]  data_byte;
  logic [2:0]  data_kind;
  logic        frame_end;
  logic        connack_ok;
  logic        connack_reject;
  logic        puback_due;
  logic [15:0] puback_id;
  logic        malformed;

  modport source (
    output valid, output frame_type, output frame_flags, output data_valid,
    output data_byte, output data_kind, output frame_end, output connack_ok,
    output connack_reject, output puback_due, output puback_id, output malformed,
    input ready
  );
  modport sink (
    input valid, input frame_type, input frame_flags, input data_valid,
    input data_byte, input data_kind, input frame_end, input connack_ok,
    input connack_reject, input puback_due, input puback_id, input malformed,
    output ready
  );
endinterface

[design/mrx_parser.sv]
// ----------------------------------------------------------------------------
// mrx_parser
// Fixed header, remaining-length and body parser. Updates its state on every
// accepted byte and produces at most one result record in the same cycle.
// ----------------------------------------------------------------------------
module mrx_parser #(
  parameter int MAX_LEN_BYTES = mrx_pkg::MRX_MAX_LEN_BYTES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          rx_byte,
  output logic                push,
  output mrx_pkg::mrx_result_t res
);
  import mrx_pkg::*;

  phase_t             phase, phase_next;
  logic [7:0]         header_byte, header_byte_next;
  logic [LEN_W-1:0]   length_accum, length_accum_next;
  logic [CNT_W-1:0]   len_cnt, len_cnt_next;
  logic [LEN_W-1:0]   body_count, body_count_next;
  logic [TOPIC_W-1:0] topic_len, topic_len_next;
  logic [15:0]        pkt_id, pkt_id_next;
  logic [7:0]         connack_code, connack_code_next;

  logic [3:0]         ftype;
  logic [1:0]         qos;
  logic [4:0]         shamt;
  logic [TOPIC_W:0]   topic_plus2;
  logic [TOPIC_W:0]   topic_plus4;
  logic [TOPIC_W:0]   fin_topic_plus4;
  logic               emit;
  logic               fin;
  kind_t              kind;

  assign ftype           = header_byte[7:4];
  assign qos             = header_byte[2:1];
  assign shamt           = 5'(len_cnt[1:0]) * 5'd7;
  assign topic_plus2     = {1'b0, topic_len} + (TOPIC_W+1)'(2);
  assign topic_plus4     = {1'b0, topic_len} + (TOPIC_W+1)'(4);
  assign fin_topic_plus4 = {1'b0, topic_len_next} + (TOPIC_W+1)'(4);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      header_byte  <= '0;
      length_accum <= '0;
      len_cnt      <= '0;
      body_count   <= '0;
      topic_len    <= '0;
      pkt_id       <= '0;
      connack_code <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      header_byte  <= header_byte_next;
      length_accum <= length_accum_next;
      len_cnt      <= len_cnt_next;
      body_count   <= body_count_next;
      topic_len    <= topic_len_next;
      pkt_id       <= pkt_id_next;
      connack_code <= connack_code_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    header_byte_next  = header_byte;
    length_accum_next = length_accum;
    len_cnt_next      = len_cnt;
    body_count_next   = body_count;
    topic_len_next    = topic_len;
    pkt_id_next       = pkt_id;
    connack_code_next = connack_code;
    emit              = 1'b0;
    fin               = 1'b0;
    kind              = KIND_OTHER;
    res               = '0;
    res.frame_type    = header_byte[7:4];
    res.frame_flags   = header_byte[3:0];

    unique case (phase)
      PH_LEN: begin
        length_accum_next = length_accum + (LEN_W'(rx_byte[6:0]) << shamt);
        len_cnt_next      = len_cnt + CNT_W'(1);
        if (rx_byte[7]) begin
          if (len_cnt_next >= CNT_W'(MAX_LEN_BYTES)) begin
            emit          = 1'b1;
            res.malformed = 1'b1;
            phase_next    = PH_IDLE;
          end
        end else if (length_accum_next == '0) begin
          emit = 1'b1;
          fin  = 1'b1;
        end else begin
          phase_next = PH_BODY;
        end
      end
      PH_BODY: begin
        emit = 1'b1;
        if (ftype == TYPE_CONNACK && body_count == LEN_W'(1)) begin
          connack_code_next = rx_byte;
        end
        if (ftype == TYPE_PUBLISH) begin
          if (body_count[LEN_W-1:1] == '0) begin
            topic_len_next = {topic_len[7:0], rx_byte};
            kind           = KIND_TOPLEN;
          end else if (body_count < LEN_W'(topic_plus2)) begin
            kind = KIND_TOPIC;
          end else if (qos != 2'd0 && body_count < LEN_W'(topic_plus4)) begin
            pkt_id_next = {pkt_id[7:0], rx_byte};
            kind        = KIND_PKTID;
          end else begin
            kind = KIND_PAYLOAD;
          end
        end
        res.data_valid  = 1'b1;
        res.data_byte   = rx_byte;
        res.data_kind   = kind;
        body_count_next = body_count + LEN_W'(1);
        if (body_count_next >= length_accum) begin
          fin = 1'b1;
        end
      end
      default: begin
        header_byte_next  = rx_byte;
        length_accum_next = '0;
        len_cnt_next      = '0;
        body_count_next   = '0;
        topic_len_next    = '0;
        pkt_id_next       = '0;
        connack_code_next = '0;
        phase_next        = PH_LEN;
      end
    endcase

    if (fin) begin
      res.frame_end = 1'b1;
      phase_next    = PH_IDLE;
      if (ftype == TYPE_CONNACK) begin
        if (length_accum_next == LEN_W'(2) && connack_code_next == 8'd0) begin
          res.connack_ok = 1'b1;
        end else begin
          res.connack_reject = 1'b1;
        end
      end else if (ftype == TYPE_PUBLISH) begin
        if (qos == QOS_ONE && length_accum_next >= LEN_W'(2) && topic_len_next != '0 &&
            length_accum_next >= LEN_W'(fin_topic_plus4)) begin
          res.puback_due = 1'b1;
          res.puback_id  = pkt_id_next;
        end
      end
    end
  end

  assign push = accept && emit;

endmodule

[design/mrx_out_buf.sv]
// ----------------------------------------------------------------------------
// mrx_out_buf
// Two-entry result buffer. The head entry drives the output channel; the
// second entry absorbs a new result while the head is stalled.
// ----------------------------------------------------------------------------
module mrx_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  mrx_pkg::mrx_result_t din,
  output logic                ready,
  output logic                out_valid,
  input  logic                out_ready,
  output mrx_pkg::mrx_result_t dout
);
  import mrx_pkg::*;

  mrx_result_t head, head_next;
  mrx_result_t skid, skid_next;
  logic        head_vld, head_vld_next;
  logic        skid_vld, skid_vld_next;
  logic        pop;

  assign pop       = head_vld && out_ready;
  assign ready     = !skid_vld;
  assign out_valid = head_vld;
  assign dout      = head;

  always_comb begin
    head_next     = pop ? skid : head;
    head_vld_next = pop ? skid_vld : head_vld;
    skid_next     = skid;
    skid_vld_next = pop ? 1'b0 : skid_vld;
    if (push) begin
      if (!head_vld_next) begin
        head_next     = din;
        head_vld_next = 1'b1;
      end else begin
        skid_next     = din;
        skid_vld_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_vld <= 1'b0;
      skid_vld <= 1'b0;
    end else begin
      head_vld <= head_vld_next;
      skid_vld <= skid_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    head <= head_next;
    skid <= skid_next;
  end

endmodule

[design/mqtt_rx_deframer.sv]
// ----------------------------------------------------------------------------
// mqtt_rx_deframer
// MQTT fixed header deframer: latches the header byte, decodes the remaining
// length and tags each body byte, reporting CONNACK, PUBACK and malformed-length events.
//
//   channel  direction  request carries
//   rx       in         one received byte (rx_byte)
//   result   out        header nibbles, tagged body byte, frame-end flags
//
// one byte per clock while rx is ready; its result, if any, enters the buffer
// the parser state updates on each accepted byte, fed straight from rx
// a two-entry result buffer keeps rx ready while the head result is stalled
// rx.ready drops only when both buffer entries hold results
// synchronous reset returns the parser to idle and empties the buffer
// ----------------------------------------------------------------------------
module mqtt_rx_deframer #(
  parameter int MAX_LEN_BYTES = mrx_pkg::MRX_MAX_LEN_BYTES
) (
  input logic        clk,
  input logic        rst,
  mrx_byte_if.sink   rx,
  mrx_result_if.source result
);
  import mrx_pkg::*;

  logic        accept;
  logic        push;
  logic        buf_ready;
  mrx_result_t parsed;
  mrx_result_t head;

  assign rx.ready = buf_ready;
  assign accept   = rx.valid && buf_ready;

  mrx_parser #(
    .MAX_LEN_BYTES(MAX_LEN_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx.rx_byte),
    .push    (push),
    .res     (parsed)
  );

  mrx_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (parsed),
    .ready     (buf_ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .dout      (head)
  );

  assign result.frame_type     = head.frame_type;
  assign result.frame_flags    = head.frame_flags;
  assign result.data_valid     = head.data_valid;
  assign result.data_byte      = head.data_byte;
  assign result.data_kind      = head.data_kind;
  assign result.frame_end      = head.frame_end;
  assign result.connack_ok     = head.connack_ok;
  assign result.connack_reject = head.connack_reject;
  assign result.puback_due     = head.puback_due;
  assign result.puback_id      = head.puback_id;
  assign result.malformed      = head.malformed;

endmodule

[design/mrx_checker.sv]
// ----------------------------------------------------------------------------
// mrx_checker
// Port-level checks of the deframer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module mrx_checker (
  input logic        clk,
  input logic        rst,
  input logic        rx_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic        frame_end,
  input logic        data_valid,
  input logic        connack_ok,
  input logic        connack_reject,
  input logic        puback_due,
  input logic        malformed
);

  // a held result stays offered
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result withdrawn while stalled");

  // input back-pressure only with a result waiting
  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    !rx_ready |-> res_valid)
    else $error("rx not ready with no result pending");

  a_end_flags: assert property (@(posedge clk) disable iff (rst)
    res_valid && (connack_ok || connack_reject || puback_due) |-> frame_end)
    else $error("frame-end flag outside frame end");

  a_connack_excl: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(connack_ok && connack_reject) && !(puback_due && connack_ok))
    else $error("conflicting frame-end reports");

  a_malformed: assert property (@(posedge clk) disable iff (rst)
    res_valid && malformed |-> !frame_end && !data_valid)
    else $error("malformed result carries frame data");

endmodule

bind mqtt_rx_deframer mrx_checker u_mrx_checker (
  .clk            (clk),
  .rst            (rst),
  .rx_ready       (rx.ready),
  .res_valid      (result.valid),
  .res_ready      (result.ready),
  .frame_end      (result.frame_end),
  .data_valid     (result.data_valid),
  .connack_ok     (result.connack_ok),
  .connack_reject (result.connack_reject),
  .puback_due     (result.puback_due),
  .malformed      (result.malformed)
);

[dv/tb_mqtt_rx_deframer.sv]
// ----------------------------------------------------------------------------
// tb_mqtt_rx_deframer
// Self-checking bench for the MQTT receive deframer. Byte requests get
// random gaps and results random stalls, except at full rate. A built-in
// deframer model tracks the header, remaining length and PUBLISH layout,
// queues the expected result of every byte, and each result is compared
// field by field. Directed frames cover CONNACK, PUBLISH layouts and length
// field corner cases. Random traffic is mostly well-formed frames, with
// truncated frames, over-long length fields and byte noise mixed in.
// ----------------------------------------------------------------------------
module tb_mqtt_rx_deframer;
  import mrx_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PRINT_CAP    = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  mrx_byte_if   rx_if ();
  mrx_result_if res_if ();

  mqtt_rx_deframer dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_if),
    .result (res_if)
  );

  // deframer model state
  phase_t      ph;
  logic [7:0]  hdr;
  logic [27:0] len_acc;
  logic [2:0]  len_cnt;
  logic [27:0] body_cnt;
  logic [15:0] topic_len;
  logic [15:0] pkt_id;
  logic [7:0]  ack_code;

  mrx_result_t expected_results[$];

  bit          gaps_on  = 1'b1;
  bit          stall_on = 1'b1;
  int unsigned bytes_sent, frames_seen, results_seen, mismatches, quiet_cycles;
  int unsigned n_puback, n_connack_ok, n_connack_rej, n_malformed;

  // ---------------------------------------------------------------- model

  function automatic kind_t body_kind(input logic [27:0] idx, input logic [7:0] b);
    int unsigned i;
    int unsigned tl;
    i = idx;
    if (hdr[7:4] == TYPE_CONNACK && i == 1) ack_code = b;
    if (hdr[7:4] != TYPE_PUBLISH) return KIND_OTHER;
    if (i < 2) begin
      topic_len = {topic_len[7:0], b};
      return KIND_TOPLEN;
    end
    tl = topic_len;
    if (i < 2 + tl) return KIND_TOPIC;
    if (hdr[2:1] != 2'd0 && i < 4 + tl) begin
      pkt_id = {pkt_id[7:0], b};
      return KIND_PKTID;
    end
    return KIND_PAYLOAD;
  endfunction

  function automatic void close_frame(inout mrx_result_t r);
    int unsigned tl;
    tl = topic_len;
    r.frame_end = 1'b1;
    if (hdr[7:4] == TYPE_CONNACK) begin
      if (len_acc == 28'd2 && ack_code == 8'd0) begin
        r.connack_ok = 1'b1;
        n_connack_ok++;
      end else begin
        r.connack_reject = 1'b1;
        n_connack_rej++;
      end
    end else if (hdr[7:4] == TYPE_PUBLISH && hdr[2:1] == QOS_ONE && len_acc >= 28'd2 &&
                 tl != 0 && len_acc >= 4 + tl) begin
      r.puback_due = 1'b1;
      r.puback_id  = pkt_id;
      n_puback++;
    end
    ph = PH_IDLE;
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    mrx_result_t r;
    r = '0;
    r.frame_type  = hdr[7:4];
    r.frame_flags = hdr[3:0];
    case (ph)
      PH_LEN: begin
        len_acc = len_acc + (28'(b[6:0]) << (7 * len_cnt[1:0]));
        len_cnt = len_cnt + 3'd1;
        if (b[7]) begin
          if (len_cnt >= MRX_MAX_LEN_BYTES) begin
            r.malformed = 1'b1;
            n_malformed++;
            ph = PH_IDLE;
            expected_results.push_back(r);
          end
        end else if (len_acc == '0) begin
          close_frame(r);
          expected_results.push_back(r);
        end else begin
          ph = PH_BODY;
        end
      end
      PH_BODY: begin
        r.data_valid = 1'b1;
        r.data_byte  = b;
        r.data_kind  = body_kind(body_cnt, b);
        body_cnt     = body_cnt + 28'd1;
        if (body_cnt >= len_acc) close_frame(r);
        expected_results.push_back(r);
      end
      default: begin
        hdr       = b;
        len_acc   = '0;
        len_cnt   = '0;
        body_cnt  = '0;
        topic_len = '0;
        pkt_id    = '0;
        ack_code  = '0;
        ph        = PH_LEN;
        frames_seen++;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    if (mismatches < PRINT_CAP)
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input int unsigned got,
                             input int unsigned want);
    if (got != want) flag_mismatch(what, got, want);
  endtask

  task automatic check_result();
    mrx_result_t want;
    results_seen++;
    if (expected_results.size() == 0) begin
      flag_mismatch("result with no request pending, data_byte", res_if.data_byte, 0);
      return;
    end
    want = expected_results.pop_front();
    check_field("frame_type", res_if.frame_type, want.frame_type);
    check_field("frame_flags", res_if.frame_flags, want.frame_flags);
    check_field("data_valid", res_if.data_valid, want.data_valid);
    check_field("data_byte", res_if.data_byte, want.data_byte);
    check_field("data_kind", res_if.data_kind, want.data_kind);
    check_field("frame_end", res_if.frame_end, want.frame_end);
    check_field("connack_ok", res_if.connack_ok, want.connack_ok);
    check_field("connack_reject", res_if.connack_reject, want.connack_reject);
    check_field("puback_due", res_if.puback_due, want.puback_due);
    check_field("puback_id", res_if.puback_id, want.puback_id);
    check_field("malformed", res_if.malformed, want.malformed);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) check_result();
      res_if.ready <= !(stall_on && $urandom_range(99) < 31);
    end
  end

  always @(posedge clk) begin
    if (rst || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no request moved for %0d cycles", QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_byte(input logic [7:0] b);
    while (gaps_on && $urandom_range(99) < 31) begin
      rx_if.valid <= 1'b0;
      @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(negedge clk);
    while (!rx_if.ready) @(negedge clk);
    @(posedge clk);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic send_bytes(input logic [7:0] bytes[$]);
    foreach (bytes[i]) send_byte(bytes[i]);
  endtask

  // least significant group first, optionally padded with empty groups
  task automatic send_length(input int unsigned len, input int unsigned pad);
    logic [7:0]  groups[$];
    int unsigned v;
    v = len;
    do begin
      groups.push_back({1'b0, v[6:0]});
      v = v >> 7;
    end while (v != 0);
    repeat (pad) if (groups.size() < MRX_MAX_LEN_BYTES) groups.push_back(8'h00);
    for (int i = 0; i < groups.size() - 1; i++) groups[i] = groups[i] | 8'h80;
    foreach (groups[i]) send_byte(groups[i]);
  endtask

  // brings the parser back to idle after noise
  task automatic finish_open_frame();
    while (ph != PH_IDLE) send_byte((ph == PH_LEN) ? 8'h00 : 8'($urandom));
  endtask

  task automatic send_random_frame();
    logic [7:0]  h;
    logic [7:0]  b;
    logic [7:0]  body[$];
    int unsigned sel, tl, len, cut, pad;
    sel = $urandom_range(99);
    pad = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0;
    if (sel < 45) begin
      h = {TYPE_PUBLISH, 4'($urandom)};
      if ($urandom_range(1) != 0) h[2:1] = QOS_ONE;
      tl = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
      body.push_back(tl[15:8]);
      body.push_back(tl[7:0]);
      repeat (tl) body.push_back(8'($urandom));
      if (h[2:1] != 2'd0) begin
        body.push_back(8'($urandom));
        body.push_back(8'($urandom));
      end
      repeat ($urandom_range(0, 6)) body.push_back(8'($urandom));
      if ($urandom_range(7) == 0) begin
        cut = $urandom_range(0, body.size() - 1);
        while (body.size() > cut) void'(body.pop_back());
      end
    end else if (sel < 65) begin
      h   = {TYPE_CONNACK, 4'($urandom)};
      len = ($urandom_range(3) != 0) ? 2 : $urandom_range(0, 4);
      repeat (len) body.push_back(8'($urandom));
      if (len >= 2 && $urandom_range(4) != 0) body[1] = 8'h00;
    end else if (sel < 85) begin
      h   = 8'($urandom);
      len = ($urandom_range(49) == 0) ? $urandom_range(130, 300) : $urandom_range(0, 10);
      repeat (len) body.push_back(8'($urandom));
    end else if (sel < 92) begin
      // length field that never terminates
      send_byte(8'($urandom));
      repeat (MRX_MAX_LEN_BYTES) send_byte({1'b1, 7'($urandom)});
      return;
    end else begin
      repeat ($urandom_range(3, 12)) begin
        if (ph == PH_LEN && len_cnt != 0) b = ($urandom_range(1) != 0) ? 8'h80 : 8'h00;
        else b = 8'($urandom);
        send_byte(b);
      end
      finish_open_frame();
      return;
    end
    send_byte(h);
    send_length(body.size(), pad);
    foreach (body[i]) send_byte(body[i]);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_connack();
    send_bytes('{{TYPE_CONNACK, 4'h0}, 8'h02, 8'h00, 8'h00});
    send_bytes('{{TYPE_CONNACK, 4'hf}, 8'h00});
  endtask

  task automatic test_publish();
    send_bytes('{{TYPE_PUBLISH, 4'h3}, 8'h06, 8'h00, 8'h01, 8'hff, 8'h12, 8'h34, 8'h80});
    send_bytes('{{TYPE_PUBLISH, 4'h2}, 8'h02, 8'h00, 8'h00});
    // qos 3, truncated inside the topic, four length bytes
    send_bytes('{{TYPE_PUBLISH, 4'h6}, 8'h83, 8'h80, 8'h80, 8'h00, 8'h00, 8'h02, 8'h41});
  endtask

  task automatic test_length_field();
    send_bytes('{8'hff, 8'h80, 8'h80, 8'h80, 8'h80});
  endtask

  task automatic test_random_traffic(input int unsigned n);
    int unsigned target;
    target = bytes_sent + n;
    while (bytes_sent < target) send_random_frame();
  endtask

  task automatic test_full_rate(input int unsigned n);
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    test_random_traffic(n);
    gaps_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  initial begin
    ph            = PH_IDLE;
    hdr           = '0;
    len_acc       = '0;
    len_cnt       = '0;
    body_cnt      = '0;
    topic_len     = '0;
    pkt_id        = '0;
    ack_code      = '0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = 8'h00;
    res_if.ready  = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_connack();
    test_publish();
    test_length_field();
    test_random_traffic(550);
    test_full_rate(250);
    test_random_traffic(300);

    rx_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d bytes in %0d frames, %0d results checked, %0d mismatches",
             bytes_sent, frames_seen, results_seen, mismatches);
    $display("connack ok %0d, connack rejected %0d, puback due %0d, malformed %0d",
             n_connack_ok, n_connack_rej, n_puback, n_malformed);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
